FILE: hdl/mhsr_pkg.sv
// ----------------------------------------------------------------------------
// mhsr_pkg: shared types and constants for the miss holding slot reserve unit
// Field widths, register map, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
package mhsr_pkg;

	localparam int unsigned SLOT_DEPTH_DEF = 16;

	localparam int unsigned LINE_W  = 64;
	localparam int unsigned TIME_W  = 64;
	localparam int unsigned LAT_W   = 32;
	localparam int unsigned CAP_W   = 5;
	localparam int unsigned DROP_W  = 32;

	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;
	// register index = byte address / 4
	localparam int unsigned REG_IDX_BIT = 2;
	localparam logic REG_SLOT_CAPACITY = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RET_RD,
		ST_RET_CHK,
		ST_CMP,
		ST_FIND,
		ST_DECIDE,
		ST_MERGE,
		ST_STALL,
		ST_RET2_RD,
		ST_RET2_CHK,
		ST_APPEND,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load_req;
		logic rd_head;
		logic rd_match;
		logic pop;
		logic cmp;
		logic find;
		logic merge;
		logic drop;
		logic stall;
		logic append;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic front_done;
		logic found;
		logic full;
		logic may_drop;
	} dp_status_t;

endpackage

FILE: hdl/mhsr_req_if.sv
// ----------------------------------------------------------------------------
// mhsr_req_if: miss request channel
// valid/ready handshake carrying one miss to be tracked.
// ----------------------------------------------------------------------------
interface mhsr_req_if;
	import mhsr_pkg::*;

	logic                valid;
	logic                ready;
	logic [LINE_W-1:0]   line_address;
	logic [TIME_W-1:0]   issue_time;
	logic [LAT_W-1:0]    fill_latency;
	logic                may_drop;

	modport source (
		output valid, line_address, issue_time, fill_latency, may_drop,
		input  ready
	);
	modport sink (
		input  valid, line_address, issue_time, fill_latency, may_drop,
		output ready
	);
endinterface

FILE: hdl/mhsr_rsp_if.sv
// ----------------------------------------------------------------------------
// mhsr_rsp_if: miss result channel
// valid/ready handshake carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface mhsr_rsp_if;
	import mhsr_pkg::*;

	logic                valid;
	logic                ready;
	logic [TIME_W-1:0]   done_time;
	logic                was_dropped;
	logic                was_merged;
	logic [TIME_W-1:0]   stall_time;
	logic [TIME_W-1:0]   stall_total;
	logic [DROP_W-1:0]   drop_total;

	modport source (
		output valid, done_time, was_dropped, was_merged, stall_time, stall_total,
		       drop_total,
		input  ready
	);
	modport sink (
		input  valid, done_time, was_dropped, was_merged, stall_time, stall_total,
		       drop_total,
		output ready
	);
endinterface

FILE: hdl/mhsr_ctrl.sv
// ----------------------------------------------------------------------------
// mhsr_ctrl: request sequencer
// Walks one request through retire, lookup, decide, merge, stall, append and result steps.
// ----------------------------------------------------------------------------
module mhsr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  mhsr_pkg::dp_status_t   status,
	output mhsr_pkg::ctrl_cmd_t    cmd
);
	import mhsr_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_RET_RD;
			ST_RET_RD:   state_d = status.empty ? ST_CMP : ST_RET_CHK;
			ST_RET_CHK:  state_d = status.front_done ? ST_RET_RD : ST_CMP;
			ST_CMP:      state_d = ST_FIND;
			ST_FIND:     state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (status.found)
					state_d = ST_MERGE;
				else if (status.full && status.may_drop)
					state_d = ST_RESULT;
				else if (status.full)
					state_d = ST_STALL;
				else
					state_d = ST_APPEND;
			end
			ST_MERGE:    state_d = ST_RESULT;
			ST_STALL:    state_d = ST_RET2_RD;
			ST_RET2_RD:  state_d = status.empty ? ST_APPEND : ST_RET2_CHK;
			ST_RET2_CHK: state_d = status.front_done ? ST_RET2_RD : ST_APPEND;
			ST_APPEND:   state_d = ST_RESULT;
			ST_RESULT:   if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:     cmd.load_req = in_valid;
			ST_RET_RD,
			ST_RET2_RD:  cmd.rd_head = !status.empty;
			ST_RET_CHK,
			ST_RET2_CHK: cmd.pop = status.front_done;
			ST_CMP:      cmd.cmp = 1'b1;
			ST_FIND:     cmd.find = 1'b1;
			ST_DECIDE: begin
				if (status.found)
					cmd.rd_match = 1'b1;
				else if (status.full && status.may_drop)
					cmd.drop = 1'b1;
				else if (status.full)
					cmd.rd_head = 1'b1;
			end
			ST_MERGE:    cmd.merge = 1'b1;
			ST_STALL:    cmd.stall = 1'b1;
			ST_APPEND:   cmd.append = 1'b1;
			ST_RESULT:   cmd.load_out = out_free;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hdl/mhsr_datapath.sv
// ----------------------------------------------------------------------------
// mhsr_datapath: slot storage and arithmetic
// Slot FIFO (line flops, completion-time memory), compare, totals, result regs.
// ----------------------------------------------------------------------------
module mhsr_datapath #(
	parameter int unsigned SLOT_DEPTH = mhsr_pkg::SLOT_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mhsr_pkg::ctrl_cmd_t           cmd,
	output mhsr_pkg::dp_status_t          status,
	input  logic [mhsr_pkg::CAP_W-1:0]    slot_capacity,
	input  logic [mhsr_pkg::LINE_W-1:0]   line_address,
	input  logic [mhsr_pkg::TIME_W-1:0]   issue_time,
	input  logic [mhsr_pkg::LAT_W-1:0]    fill_latency,
	input  logic                          may_drop,
	output logic [mhsr_pkg::TIME_W-1:0]   done_time,
	output logic                          was_dropped,
	output logic                          was_merged,
	output logic [mhsr_pkg::TIME_W-1:0]   stall_time,
	output logic [mhsr_pkg::TIME_W-1:0]   stall_total,
	output logic [mhsr_pkg::DROP_W-1:0]   drop_total
);
	import mhsr_pkg::*;

	localparam int unsigned IDX_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(SLOT_DEPTH + 1);
	localparam int unsigned SUM_W = CNT_W + 1;
	localparam int unsigned CC_W  = 8;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(SLOT_DEPTH);
	localparam logic [CC_W-1:0]  DEPTH_C = CC_W'(SLOT_DEPTH);

	// request hold
	logic [LINE_W-1:0] req_line_q;
	logic [TIME_W-1:0] issue_q;
	logic [LAT_W-1:0]  lat_q;
	logic              may_drop_q;
	logic [CNT_W-1:0]  cap_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] start_q;

	// slot FIFO
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [LINE_W-1:0] line_q [SLOT_DEPTH];
	logic [TIME_W-1:0] done_mem [SLOT_DEPTH];
	logic [TIME_W-1:0] rdata_q;

	// lookup
	logic [SLOT_DEPTH-1:0] hit_q;
	logic                  found_q;
	logic [IDX_W-1:0]      match_q;

	// totals and per-request result
	logic [TIME_W-1:0] stall_sum_q;
	logic [DROP_W-1:0] drop_q;
	logic [TIME_W-1:0] res_done_q;
	logic [TIME_W-1:0] res_stall_q;
	logic              res_drop_q;
	logic              res_merge_q;

	logic [TIME_W-1:0] out_done_q;
	logic [TIME_W-1:0] out_stall_q;
	logic [TIME_W-1:0] out_sum_q;
	logic [DROP_W-1:0] out_drop_total_q;
	logic              out_drop_q;
	logic              out_merge_q;

	// combinational
	logic [CC_W-1:0]       cap_ext;
	logic [CC_W-1:0]       cap_c;
	logic [SUM_W-1:0]      head_sum;
	logic [IDX_W-1:0]      head_next;
	logic [SUM_W-1:0]      tail_sum;
	logic [IDX_W-1:0]      tail_idx;
	logic [SLOT_DEPTH-1:0] hit_d;
	logic                  found_d;
	logic [IDX_W-1:0]      match_d;
	logic [TIME_W-1:0]     append_done;
	logic [TIME_W-1:0]     stall_v;
	logic [TIME_W:0]       stall_add;
	logic [TIME_W-1:0]     stall_sum_next;
	logic [IDX_W-1:0]      rd_addr;
	logic                  mem_we;

	// capacity: zero counts as one, above depth saturates
	always_comb begin
		cap_ext = CC_W'(slot_capacity);
		if (cap_ext == '0)
			cap_c = CC_W'(1);
		else if (cap_ext > DEPTH_C)
			cap_c = DEPTH_C;
		else
			cap_c = cap_ext;
	end

	always_comb begin
		head_sum  = SUM_W'(head_q) + SUM_W'(1);
		head_next = (head_sum == DEPTH_S) ? '0 : head_sum[IDX_W-1:0];
		tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
		if (tail_sum >= DEPTH_S)
			tail_sum = tail_sum - DEPTH_S;
		tail_idx  = tail_sum[IDX_W-1:0];
	end

	// line compare on every slot, masked by the occupied window
	always_comb begin
		logic [SUM_W-1:0] ks;
		logic [SUM_W-1:0] off;
		for (int k = 0; k < SLOT_DEPTH; k++) begin
			ks  = SUM_W'(k);
			off = (ks >= SUM_W'(head_q)) ? (ks - SUM_W'(head_q))
			                              : (ks + DEPTH_S - SUM_W'(head_q));
			hit_d[k] = (off < SUM_W'(count_q)) && (line_q[k] == req_line_q);
		end
	end

	// first hit counted from the head
	always_comb begin
		logic [SUM_W-1:0] s;
		found_d = 1'b0;
		match_d = '0;
		for (int p = SLOT_DEPTH - 1; p >= 0; p--) begin
			s = SUM_W'(head_q) + SUM_W'(p);
			if (s >= DEPTH_S)
				s = s - DEPTH_S;
			if (hit_q[s[IDX_W-1:0]]) begin
				found_d = 1'b1;
				match_d = s[IDX_W-1:0];
			end
		end
	end

	assign append_done = start_q + TIME_W'(lat_q);
	assign stall_v     = rdata_q - issue_q;
	assign stall_add   = {1'b0, stall_sum_q} + {1'b0, stall_v};
	assign stall_sum_next = stall_add[TIME_W] ? '1 : stall_add[TIME_W-1:0];
	assign rd_addr     = cmd.rd_match ? match_q : head_q;
	assign mem_we      = cmd.append && (count_q != CNT_W'(SLOT_DEPTH));

	assign status.empty      = (count_q == '0);
	assign status.front_done = (rdata_q <= now_q);
	assign status.found      = found_q;
	assign status.full       = (count_q >= cap_q);
	assign status.may_drop   = may_drop_q;

	// completion-time memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			done_mem[tail_idx] <= append_done;
		if (cmd.rd_head || cmd.rd_match)
			rdata_q <= done_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			line_q[tail_idx] <= req_line_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			stall_sum_q <= '0;
			drop_q      <= '0;
		end else begin
			if (cmd.pop) begin
				head_q  <= head_next;
				count_q <= count_q - CNT_W'(1);
			end
			if (mem_we)
				count_q <= count_q + CNT_W'(1);
			if (cmd.stall)
				stall_sum_q <= stall_sum_next;
			if (cmd.drop && (drop_q != '1))
				drop_q <= drop_q + DROP_W'(1);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_line_q  <= line_address;
			issue_q     <= issue_time;
			lat_q       <= fill_latency;
			may_drop_q  <= may_drop;
			cap_q       <= CNT_W'(cap_c);
			now_q       <= issue_time;
			start_q     <= issue_time;
			res_done_q  <= '0;
			res_stall_q <= '0;
			res_drop_q  <= 1'b0;
			res_merge_q <= 1'b0;
		end
		if (cmd.cmp)
			hit_q <= hit_d;
		if (cmd.find) begin
			found_q <= found_d;
			match_q <= match_d;
		end
		if (cmd.merge) begin
			res_done_q  <= rdata_q;
			res_merge_q <= 1'b1;
		end
		if (cmd.drop)
			res_drop_q <= 1'b1;
		if (cmd.stall) begin
			res_stall_q <= stall_v;
			now_q       <= rdata_q;
			start_q     <= rdata_q;
		end
		if (cmd.append)
			res_done_q <= append_done;
		if (cmd.load_out) begin
			out_done_q       <= res_done_q;
			out_stall_q      <= res_stall_q;
			out_drop_q       <= res_drop_q;
			out_merge_q      <= res_merge_q;
			out_sum_q        <= stall_sum_q;
			out_drop_total_q <= drop_q;
		end
	end

	assign done_time   = out_done_q;
	assign was_dropped = out_drop_q;
	assign was_merged  = out_merge_q;
	assign stall_time  = out_stall_q;
	assign stall_total = out_sum_q;
	assign drop_total  = out_drop_total_q;

endmodule

FILE: hdl/miss_holding_slot_reserve_unit.sv
// ----------------------------------------------------------------------------
// miss_holding_slot_reserve_unit: in-flight miss slot file
// FIFO of outstanding line misses with merge, drop-when-full and stall timing.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              contents
//  req       in   valid/ready            line_address, issue_time, fill_latency,
//                                        may_drop
//  rsp       out  valid/ready            done_time, was_dropped, was_merged,
//                                        stall_time, stall_total, drop_total
//  apb       in   psel/penable, pready=1 slot_capacity at byte address 0
//
//  Sequencing: one request at a time. Retirement reads the head completion time
//  from the slot memory's single registered read port, one entry after another;
//  the line lookup is a registered compare over all slots plus a registered
//  priority pick from the head.
//  Reset: FIFO empty, totals zero, capacity at its reset value; no clearing pass.
//  Stalls: req is taken whenever the sequencer is idle, even while the last
//  result still sits in the rsp register; the next result waits for that slot,
//  so a low rsp.ready also holds up that request.
//
module miss_holding_slot_reserve_unit #(
	parameter int unsigned SLOT_DEPTH = mhsr_pkg::SLOT_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mhsr_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [mhsr_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [mhsr_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	mhsr_req_if.sink                          req,
	mhsr_rsp_if.source                        rsp
);
	import mhsr_pkg::*;

	// capacity reset: the full depth, as far as the register can hold it
	localparam int unsigned CAP_MAX = (1 << CAP_W) - 1;
	localparam logic [CAP_W-1:0] CAP_RST =
		CAP_W'((SLOT_DEPTH > CAP_MAX) ? CAP_MAX : SLOT_DEPTH);

	logic [CAP_W-1:0] cap_q;
	logic             reg_sel;
	ctrl_cmd_t        cmd;
	dp_status_t       status;

	// config register: write lands on the access phase
	assign pready  = 1'b1;
	assign reg_sel = (paddr[REG_IDX_BIT] == REG_SLOT_CAPACITY);
	assign prdata  = reg_sel ? APB_DATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	mhsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mhsr_datapath #(
		.SLOT_DEPTH (SLOT_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.slot_capacity (cap_q),
		.line_address  (req.line_address),
		.issue_time    (req.issue_time),
		.fill_latency  (req.fill_latency),
		.may_drop      (req.may_drop),
		.done_time     (rsp.done_time),
		.was_dropped   (rsp.was_dropped),
		.was_merged    (rsp.was_merged),
		.stall_time    (rsp.stall_time),
		.stall_total   (rsp.stall_total),
		.drop_total    (rsp.drop_total)
	);

endmodule

FILE: hdl/mhsr_chk.sv
// ----------------------------------------------------------------------------
// mhsr_chk: port-level checks for the miss slot unit
// Outstanding request bound, result consistency and rsp hold under stall.
// ----------------------------------------------------------------------------
module mhsr_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [mhsr_pkg::TIME_W-1:0]   done_time,
	input logic                          was_dropped,
	input logic                          was_merged,
	input logic [mhsr_pkg::TIME_W-1:0]   stall_time,
	input logic [mhsr_pkg::TIME_W-1:0]   stall_total,
	input logic [mhsr_pkg::DROP_W-1:0]   drop_total
);
	import mhsr_pkg::*;

	logic [1:0] pend_q;
	logic       req_fire;
	logic       rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (req_fire && !rsp_fire)
			pend_q <= pend_q + 2'd1;
		else if (rsp_fire && !req_fire)
			pend_q <= pend_q - 2'd1;
	end

	// at most one request in work plus one result waiting, none invented
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q <= 2'd2) && !(rsp_valid && pend_q == 2'd0))
		else $error("request/result count out of bounds");

	a_drop_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && was_dropped |->
		done_time == '0 && stall_time == '0 && !was_merged && drop_total != '0)
		else $error("dropped result malformed");

	a_merge_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && was_merged |-> stall_time == '0 && !was_dropped)
		else $error("merged result malformed");

	a_total_covers: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> stall_total >= stall_time)
		else $error("stall total below this stall");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(done_time))
		else $error("result changed while stalled");

endmodule

bind miss_holding_slot_reserve_unit mhsr_chk u_mhsr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.done_time   (rsp.done_time),
	.was_dropped (rsp.was_dropped),
	.was_merged  (rsp.was_merged),
	.stall_time  (rsp.stall_time),
	.stall_total (rsp.stall_total),
	.drop_total  (rsp.drop_total)
);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for miss_holding_slot_reserve_unit
// Drives miss requests over the req channel and slot_capacity over APB. A
// built-in prediction of the slot file, or a fixed outcome given by some directed
// rows, supplies each expected outcome, which is matched field by field against the rsp channel in order.
// ----------------------------------------------------------------------------
module tb_top;
	import mhsr_pkg::*;

	localparam int unsigned DEPTH         = SLOT_DEPTH_DEF;
	localparam int unsigned QUIET_LIMIT   = 5000;  // cycles with no handshake at all
	localparam int unsigned TAIL_CYCLES   = 100;   // trailing watch for stray results
	localparam int unsigned SEGMENTS      = 6;
	localparam int unsigned ITEMS_PER_SEG = 225;
	localparam int unsigned POOL_SIZE     = 32;
	localparam int unsigned EARLY_ROWS    = 18;    // rows before the random part
	localparam int unsigned TABLE_ROWS    = 22;    // the rest saturate the stall sum
	localparam int unsigned PRINT_LIMIT   = 100;

	localparam logic [TIME_W-1:0]     T_MAX    = '1;
	localparam logic [LAT_W-1:0]      L_MAX    = '1;
	localparam logic [APB_ADDR_W-1:0] CAP_ADDR = APB_ADDR_W'(REG_SLOT_CAPACITY) << REG_IDX_BIT;

	// capacity per random segment; the last one is drawn at random
	localparam logic [CAP_W-1:0] SEG_CAPS [SEGMENTS] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8};

	typedef struct packed {
		logic [LINE_W-1:0] line_address;
		logic [TIME_W-1:0] issue_time;
		logic [LAT_W-1:0]  fill_latency;
		logic              may_drop;
	} miss_req_t;

	typedef struct packed {
		logic [TIME_W-1:0] done_time;
		logic              was_dropped;
		logic              was_merged;
		logic [TIME_W-1:0] stall_time;
		logic [TIME_W-1:0] stall_total;
		logic [DROP_W-1:0] drop_total;
	} miss_rsp_t;

	// one directed step: optional capacity write first, then the request;
	// a fixed outcome is given only where it is obvious by hand
	typedef struct packed {
		logic             set_cap;
		logic [CAP_W-1:0] cap;
		miss_req_t        req;
		logic             fixed;
		miss_rsp_t        want;
	} dir_row_t;

	localparam dir_row_t DIR_TABLE [TABLE_ROWS] = '{
		// empty file: zero everything, appends with done 0
		'{1'b0, 5'd0, '{64'd0, 64'd0, 32'd0, 1'b0},
			1'b1, '{64'd0, 1'b0, 1'b0, 64'd0, 64'd0, 32'd0}},
		// all-ones fields: old entry retires, done wraps
		'{1'b0, 5'd0, '{T_MAX, T_MAX, L_MAX, 1'b1},
			1'b1, '{64'h0000_0000_FFFF_FFFE, 1'b0, 1'b0, 64'd0, 64'd0, 32'd0}},
		// same line in flight: merge wins over the drop flag
		'{1'b0, 5'd0, '{T_MAX, 64'd5, 32'd7, 1'b1},
			1'b1, '{64'h0000_0000_FFFF_FFFE, 1'b0, 1'b1, 64'd0, 64'd0, 32'd0}},
		// capacity 1 and full: prefetch dropped
		'{1'b1, 5'd1, '{64'd1, 64'd10, 32'd4, 1'b1},
			1'b1, '{64'd0, 1'b1, 1'b0, 64'd0, 64'd0, 32'd1}},
		// same miss, not droppable: stalls behind the front
		'{1'b0, 5'd0, '{64'd1, 64'd10, 32'd4, 1'b0}, 1'b0, '0},
		// capacity zero behaves as one
		'{1'b1, 5'd0, '{64'd2, 64'd0, 32'd0, 1'b1}, 1'b0, '0},
		'{1'b0, 5'd0, '{64'd2, 64'd0, 32'd0, 1'b0}, 1'b0, '0},
		// capacity above depth saturates: fill a few slots
		'{1'b1, 5'd31, '{64'd10, 64'd100, 32'd1000, 1'b0}, 1'b0, '0},
		'{1'b0, 5'd0, '{64'd11, 64'd100, 32'd1000, 1'b0}, 1'b0, '0},
		'{1'b0, 5'd0, '{64'd12, 64'd101, 32'd1000, 1'b1}, 1'b0, '0},
		'{1'b0, 5'd0, '{64'd13, 64'd102, 32'd0, 1'b0}, 1'b0, '0},
		// capacity lowered under occupancy: full, drop then stall
		'{1'b1, 5'd2, '{64'd20, 64'd200, 32'd5, 1'b1}, 1'b0, '0},
		'{1'b0, 5'd0, '{64'd20, 64'd200, 32'd5, 1'b0}, 1'b0, '0},
		'{1'b0, 5'd0, '{64'h8000_0000_0000_0000, 64'd300, 32'd50, 1'b0}, 1'b0, '0},
		'{1'b0, 5'd0, '{64'h8000_0000_0000_0000, 64'd301, 32'd9, 1'b1}, 1'b0, '0},
		// time wrap: done lands past zero
		'{1'b1, 5'd16, '{64'd0, 64'hFFFF_FFFF_FFFF_FFF0, 32'd64, 1'b0}, 1'b0, '0},
		'{1'b0, 5'd0, '{64'd1, 64'd16, 32'd0, 1'b0}, 1'b0, '0},
		'{1'b0, 5'd0, '{64'd0, 64'd48, 32'd1, 1'b0}, 1'b0, '0},
		// late rows: front far ahead of issue, stall sum saturates
		'{1'b1, 5'd1, '{64'hA5A5_A5A5_A5A5_A5A5, 64'hFFFF_FFFF_FFFF_FF9C, 32'd50, 1'b0},
			1'b0, '0},
		'{1'b0, 5'd0, '{64'h5A5A_5A5A_5A5A_5A5A, 64'd0, 32'd0, 1'b0}, 1'b0, '0},
		'{1'b0, 5'd0, '{64'h5A5A_5A5A_5A5A_5A5A, 64'd1, 32'd3, 1'b1}, 1'b0, '0},
		'{1'b0, 5'd0, '{64'h0F0F_0F0F_0F0F_0F0F, 64'd2, 32'd3, 1'b0}, 1'b0, '0}
	};

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	mhsr_req_if req_if();
	mhsr_rsp_if rsp_if();

	miss_holding_slot_reserve_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.rsp     (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow slot file: same FIFO of (line, done time) the unit keeps
	// ------------------------------------------------------------------
	logic [LINE_W-1:0] inflight_line [DEPTH];
	logic [TIME_W-1:0] inflight_done [DEPTH];
	int unsigned       inflight_front    = 0;
	int unsigned       inflight_count    = 0;
	logic [TIME_W-1:0] stall_sum_pred    = '0;
	logic [DROP_W-1:0] drop_count_pred   = '0;
	logic [CAP_W-1:0]  capacity_setting  = CAP_W'(DEPTH);

	miss_rsp_t pending_outcomes [$];

	int src_idle_pct  = 31;
	int snk_idle_pct  = 74;
	int error_count   = 0;
	int result_count  = 0;
	int quiet_cycles  = 0;

	// pop from the front only, while the front fill is done by 'now'
	function automatic void retire_through(input logic [TIME_W-1:0] now);
		while (inflight_count > 0 && inflight_done[inflight_front] <= now) begin
			inflight_front = (inflight_front + 1) % DEPTH;
			inflight_count--;
		end
	endfunction

	function automatic miss_rsp_t predict_miss_outcome(input miss_req_t r);
		miss_rsp_t         o;
		int unsigned       eff_cap;
		int unsigned       k;
		int unsigned       tail;
		logic [TIME_W-1:0] unblock;
		o = '0;
		// zero counts as one, anything past the physical depth clamps
		if (capacity_setting == 0)
			eff_cap = 1;
		else if (capacity_setting > DEPTH)
			eff_cap = DEPTH;
		else
			eff_cap = capacity_setting;
		unblock = r.issue_time;
		retire_through(r.issue_time);

		// first matching line from the front supplies the done time
		for (k = 0; k < inflight_count && !o.was_merged; k++) begin
			if (inflight_line[(inflight_front + k) % DEPTH] == r.line_address) begin
				o.was_merged = 1'b1;
				o.done_time  = inflight_done[(inflight_front + k) % DEPTH];
			end
		end

		if (!o.was_merged) begin
			// occupancy may sit above a freshly lowered capacity: still full
			if (inflight_count >= eff_cap) begin
				if (r.may_drop) begin
					o.was_dropped = 1'b1;
					if (drop_count_pred != '1)
						drop_count_pred++;
				end else begin
					unblock      = inflight_done[inflight_front];
					o.stall_time = unblock - r.issue_time;
					// saturating add: overflow iff sum > MAX - stall
					if (stall_sum_pred > ~o.stall_time)
						stall_sum_pred = '1;
					else
						stall_sum_pred = stall_sum_pred + o.stall_time;
					retire_through(unblock);
				end
			end
			if (!o.was_dropped) begin
				o.done_time = ((unblock > r.issue_time) ? unblock : r.issue_time)
					+ TIME_W'(r.fill_latency);
				if (inflight_count < DEPTH) begin
					tail = (inflight_front + inflight_count) % DEPTH;
					inflight_line[tail] = r.line_address;
					inflight_done[tail] = o.done_time;
					inflight_count++;
				end
			end
		end
		o.stall_total = stall_sum_pred;
		o.drop_total  = drop_count_pred;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (error_count < PRINT_LIMIT)
			$display("%0t: request %0d %s: got %h, expected %h",
				$time, result_count, what, got, want);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// hold-off and idle gaps lower valid once, then valid rises for the
	// request; the outcome is queued at the accepting edge
	task automatic send_miss(input miss_req_t r, input bit drain_first, input bit fixed,
			input miss_rsp_t fixed_want);
		miss_rsp_t predicted;
		if (drain_first || ($urandom_range(0, 99) < src_idle_pct)) begin
			req_if.valid <= 1'b0;
			if (drain_first)
				while (pending_outcomes.size() != 0)
					@(posedge clk);
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct);
		end
		req_if.valid        <= 1'b1;
		req_if.line_address <= r.line_address;
		req_if.issue_time   <= r.issue_time;
		req_if.fill_latency <= r.fill_latency;
		req_if.may_drop     <= r.may_drop;
		do
			@(posedge clk);
		while (!req_if.ready);
		predicted = predict_miss_outcome(r);
		pending_outcomes.insert(pending_outcomes.size(), fixed ? fixed_want : predicted);
	endtask

	// capacity changes only with the unit drained; read back afterwards
	task automatic write_slot_capacity(input logic [CAP_W-1:0] value);
		req_if.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAP_ADDR;
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		capacity_setting = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[CAP_W-1:0] !== value)
			report_mismatch("slot_capacity readback", 64'(prdata), 64'(value));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		miss_req_t         r;
		logic [LINE_W-1:0] line_pool [POOL_SIZE];
		logic [TIME_W-1:0] now_time;
		int                row;
		int                seg;
		int                n;
		int                kind;
		req_if.valid        <= 1'b0;
		req_if.line_address <= '0;
		req_if.issue_time   <= '0;
		req_if.fill_latency <= '0;
		req_if.may_drop     <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, first part (reset capacity until a row changes it)
		for (row = 0; row < EARLY_ROWS; row++) begin
			if (DIR_TABLE[row].set_cap)
				write_slot_capacity(DIR_TABLE[row].cap);
			send_miss(DIR_TABLE[row].req, 1'b0, DIR_TABLE[row].fixed, DIR_TABLE[row].want);
		end

		// random part: a handful of hot lines and a slowly advancing clock so
		// that merges, full files, drops and stalls all come up often
		for (n = 0; n < POOL_SIZE; n++)
			line_pool[n] = {$urandom, $urandom};
		now_time = 64'd1000;
		for (seg = 0; seg < SEGMENTS; seg++) begin
			// sender slow / receiver slower, then swapped, then no idling
			case (seg / 2)
				0: begin
					src_idle_pct = 31;
					snk_idle_pct = 74;
				end
				1: begin
					src_idle_pct = 74;
					snk_idle_pct = 31;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			write_slot_capacity((seg == SEGMENTS - 1) ? CAP_W'($urandom_range(0, 31))
				: SEG_CAPS[seg]);
			for (n = 0; n < ITEMS_PER_SEG; n++) begin
				kind = $urandom_range(0, 99);
				if (kind < 4)
					line_pool[$urandom_range(0, POOL_SIZE - 1)] = {$urandom, $urandom};
				r.line_address = line_pool[$urandom_range(0, POOL_SIZE - 1)];
				if (kind < 90) begin
					now_time       = now_time + 64'($urandom_range(0, 12));
					r.issue_time   = now_time;
					r.fill_latency = (kind < 84) ? LAT_W'($urandom_range(0, 150)) : $urandom;
				end else begin
					// noise: stray lines and latencies; time jumps only in the
					// last segment, since a jump backwards saturates the stall sum
					r.line_address = {$urandom, $urandom};
					r.fill_latency = $urandom;
					if (seg == SEGMENTS - 1)
						now_time = {$urandom, $urandom};
					r.issue_time   = now_time;
				end
				r.may_drop = ($urandom_range(0, 2) == 0);
				send_miss(r, (n == 100) || ($urandom_range(0, 99) == 0), 1'b0, '0);
			end
		end

		// directed rows, closing part
		for (row = EARLY_ROWS; row < TABLE_ROWS; row++) begin
			if (DIR_TABLE[row].set_cap)
				write_slot_capacity(DIR_TABLE[row].cap);
			send_miss(DIR_TABLE[row].req, 1'b0, DIR_TABLE[row].fixed, DIR_TABLE[row].want);
		end
		req_if.valid <= 1'b0;

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("miss_holding_slot_reserve_unit test passed");
		else
			$display("miss_holding_slot_reserve_unit test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: random back-pressure and in-order checking
	// ------------------------------------------------------------------
	task automatic check_outcome();
		miss_rsp_t want;
		if (pending_outcomes.size() == 0) begin
			report_mismatch("unexpected result, done_time", rsp_if.done_time, '0);
			return;
		end
		want = pending_outcomes[0];
		pending_outcomes.delete(0);
		if (rsp_if.done_time !== want.done_time)
			report_mismatch("done_time", rsp_if.done_time, want.done_time);
		if (rsp_if.was_dropped !== want.was_dropped)
			report_mismatch("was_dropped", 64'(rsp_if.was_dropped), 64'(want.was_dropped));
		if (rsp_if.was_merged !== want.was_merged)
			report_mismatch("was_merged", 64'(rsp_if.was_merged), 64'(want.was_merged));
		if (rsp_if.stall_time !== want.stall_time)
			report_mismatch("stall_time", rsp_if.stall_time, want.stall_time);
		if (rsp_if.stall_total !== want.stall_total)
			report_mismatch("stall_total", rsp_if.stall_total, want.stall_total);
		if (rsp_if.drop_total !== want.drop_total)
			report_mismatch("drop_total", 64'(rsp_if.drop_total), 64'(want.drop_total));
		result_count++;
	endtask

	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
				check_outcome();
			rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// any handshake on either channel counts as progress
	always @(posedge clk) begin
		if ((req_if.valid === 1'b1 && req_if.ready === 1'b1)
				|| (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
			$display("miss_holding_slot_reserve_unit test failed");
			$finish;
		end
	end

endmodule

FILE: sim.f
hdl/mhsr_pkg.sv
hdl/mhsr_req_if.sv
hdl/mhsr_rsp_if.sv
hdl/mhsr_ctrl.sv
hdl/mhsr_datapath.sv
hdl/miss_holding_slot_reserve_unit.sv
hdl/mhsr_chk.sv
sim/tb_top.sv
